// ===== src/light_level_smoother_with_hysteresis_defines.svh =====
// assertion macros for the light level smoother
`ifndef LIGHT_LEVEL_SMOOTHER_WITH_HYSTERESIS_DEFINES_SVH
`define LIGHT_LEVEL_SMOOTHER_WITH_HYSTERESIS_DEFINES_SVH

`ifndef ASSERT_OFF

// condition implies consequence in the same cycle
`define LLS_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define LLS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`else

`define LLS_ASSERT_IMPL(label, clk, rst, cond, cons)
`define LLS_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ===== src/lls_pkg.sv =====
package lls_pkg;

   localparam int WINDOW = 10;

   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 12;
   localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int COUNT_W  = $clog2(WINDOW + 1);
   localparam int TOTAL_W  = $clog2(WINDOW * 4095 + 1);
   localparam int DVD_W    = AVG_W + COUNT_W;
   localparam int STEP_W   = $clog2(AVG_W + 1);
   localparam int PROD_W   = 24;

   localparam int MV_FULL_SCALE   = 3300;
   localparam int CODE_FULL_SCALE = 4095;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONVERT_RAW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_LOW  = 2'd2;

   localparam logic             CONVERT_RAW_RESET    = 1'b1;
   localparam logic [AVG_W-1:0] THRESHOLD_HIGH_RESET = 12'd600;
   localparam logic [AVG_W-1:0] THRESHOLD_LOW_RESET  = 12'd400;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/lls_divider.sv =====
module lls_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lls_pkg::DVD_W-1:0]    dividend,
   input  logic [lls_pkg::COUNT_W-1:0]  divisor,
   output logic [lls_pkg::AVG_W-1:0]    quotient,
   output lls_pkg::div_status_type      status
);

   logic [lls_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [lls_pkg::AVG_W-1:0]   quo_ff, quo_in;
   logic [lls_pkg::COUNT_W-1:0] dsr_ff;
   logic [lls_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [lls_pkg::COUNT_W:0]   trial;
   logic [lls_pkg::COUNT_W:0]   diff;
   logic                        fits;

   // one quotient bit per cycle, msb first
   always_comb begin
      trial   = {rem_ff, quo_ff[lls_pkg::AVG_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = fits ? diff[lls_pkg::COUNT_W-1:0] : trial[lls_pkg::COUNT_W-1:0];
      quo_in  = {quo_ff[lls_pkg::AVG_W-2:0], fits};
      step_in = step_ff - lls_pkg::STEP_W'(1);
      busy_in = busy_ff && (step_ff != lls_pkg::STEP_W'(1));
      done_in = busy_ff && (step_ff == lls_pkg::STEP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= lls_pkg::STEP_W'(lls_pkg::AVG_W);
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) begin
            step_ff <= step_in;
         end
      end
   end

   // quotient known to fit, so the upper dividend bits seed the remainder
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[lls_pkg::DVD_W-1:lls_pkg::AVG_W];
         quo_ff <= dividend[lls_pkg::AVG_W-1:0];
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== src/light_level_smoother_with_hysteresis.sv =====
// light level smoother with hysteresis
//
// req channel: one sensor sample per request, req_tdata[11:0]. when
// convert_raw is set the sample is a 12-bit converter code scaled to mV,
// otherwise it is taken as mV.
// rsp channel: one result per request, rsp_tdata[11:0] holds the mean of
// the last samples in mV, rsp_tuser carries bright, led_on and changed.
// csr channel: register writes by index, always ready; write only while idle.
//
// a request goes from acceptance to a valid result through these steps:
// the scaling estimate, its rounding fix and the window update, the
// divider load, the bit-serial divider, the divider done flag and the
// registering of the result. one request is worked at a time; a new
// request is taken in the cycle after the result is registered.
// a stalled rsp channel holds the result; the next request is then worked
// through and waits at the end until the output register frees.
// reset empties the window, clears the running total, sets the state to
// dark and restores the register defaults.
`include "light_level_smoother_with_hysteresis_defines.svh"

module light_level_smoother_with_hysteresis (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // sample[11:0], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // average_mv[11:0], zero pad
   output logic [2:0]                        rsp_tuser,   // bright, led_on, changed
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lls_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lls_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EST   = 3'd1;
   localparam logic [2:0] S_FIX   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   logic                        convert_ff;
   logic [lls_pkg::AVG_W-1:0]   thr_high_ff;
   logic [lls_pkg::AVG_W-1:0]   thr_low_ff;

   logic [lls_pkg::SAMPLE_W-1:0] sample_ff;
   logic [lls_pkg::PROD_W-1:0]   prod_ff;
   logic [lls_pkg::AVG_W-1:0]    est_ff, est_in;
   logic [lls_pkg::PROD_W:0]     est_sum;
   logic [lls_pkg::PROD_W:0]     est_back;
   logic [lls_pkg::PROD_W:0]     est_rem;
   logic [lls_pkg::AVG_W-1:0]    mv;

   logic [lls_pkg::SAMPLE_W-1:0] window_ff [lls_pkg::WINDOW];
   logic [lls_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [lls_pkg::COUNT_W-1:0]  fill_ff, fill_in;
   logic [lls_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic                         full;
   logic                         bright_ff, bright_in;

   logic                         div_start;
   logic [lls_pkg::AVG_W-1:0]    avg;
   lls_pkg::div_status_type      div_status;

   logic                         rsp_valid_ff;
   logic [lls_pkg::AVG_W-1:0]    rsp_avg_ff;
   logic [2:0]                   rsp_user_ff;
   logic                         out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == S_START);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         convert_ff  <= lls_pkg::CONVERT_RAW_RESET;
         thr_high_ff <= lls_pkg::THRESHOLD_HIGH_RESET;
         thr_low_ff  <= lls_pkg::THRESHOLD_LOW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lls_pkg::CSR_CONVERT_RAW:    convert_ff  <= csr_data[0];
            lls_pkg::CSR_THRESHOLD_HIGH: thr_high_ff <= csr_data[lls_pkg::AVG_W-1:0];
            lls_pkg::CSR_THRESHOLD_LOW:  thr_low_ff  <= csr_data[lls_pkg::AVG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // code to mV: x/4095 estimated as (x + x/4096)/4096, low by at most one
   always_comb begin
      est_sum  = {1'b0, prod_ff} + (lls_pkg::PROD_W+1)'(prod_ff >> 12);
      est_in   = est_sum[lls_pkg::PROD_W-1:12];
      est_back = (lls_pkg::PROD_W+1)'({est_ff, 12'b0}) - (lls_pkg::PROD_W+1)'(est_ff);
      est_rem  = {1'b0, prod_ff} - est_back;
      if (!convert_ff) begin
         mv = sample_ff;
      end else if (est_rem >= (lls_pkg::PROD_W+1)'(lls_pkg::CODE_FULL_SCALE)) begin
         mv = est_ff + lls_pkg::AVG_W'(1);
      end else begin
         mv = est_ff;
      end
   end

   // window update
   always_comb begin
      full     = (fill_ff == lls_pkg::COUNT_W'(lls_pkg::WINDOW));
      fill_in  = full ? fill_ff : fill_ff + lls_pkg::COUNT_W'(1);
      total_in = total_ff + lls_pkg::TOTAL_W'(mv)
                 - (full ? lls_pkg::TOTAL_W'(window_ff[slot_ff]) : lls_pkg::TOTAL_W'(0));
      slot_in  = (slot_ff == lls_pkg::SLOT_W'(lls_pkg::WINDOW - 1))
                 ? '0 : slot_ff + lls_pkg::SLOT_W'(1);
      bright_in = bright_ff ? (avg > thr_low_ff) : (avg >= thr_high_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_EST;
         S_EST:   state_in = S_FIX;
         S_FIX:   state_in = S_START;
         S_START: state_in = S_DIV;
         S_DIV:   if (div_status.done) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         slot_ff   <= '0;
         fill_ff   <= '0;
         total_ff  <= '0;
         bright_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FIX) begin
            slot_ff  <= slot_in;
            fill_ff  <= fill_in;
            total_ff <= total_in;
         end
         if (state_ff == S_OUT && out_free) begin
            bright_ff <= bright_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata[lls_pkg::SAMPLE_W-1:0];
         prod_ff   <= lls_pkg::PROD_W'(req_tdata[lls_pkg::SAMPLE_W-1:0])
                      * lls_pkg::PROD_W'(lls_pkg::MV_FULL_SCALE);
      end
      if (state_ff == S_EST) begin
         est_ff <= est_in;
      end
      if (state_ff == S_FIX) begin
         window_ff[slot_ff] <= mv;
      end
   end

   lls_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lls_pkg::DVD_W'(total_ff)),
      .divisor  (fill_ff),
      .quotient (avg),
      .status   (div_status)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_avg_ff  <= avg;
         rsp_user_ff <= {bright_in != bright_ff, !bright_in, bright_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_avg_ff};
   assign rsp_tuser  = rsp_user_ff;

   `LLS_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= lls_pkg::COUNT_W'(lls_pkg::WINDOW))
   `LLS_ASSERT_IMPL(a_slot_bound, clock, reset, 1'b1, {1'b0, slot_ff} < (lls_pkg::SLOT_W+1)'(lls_pkg::WINDOW))
   `LLS_ASSERT_IMPL(a_div_in_div, clock, reset, div_status.busy, state_ff == S_DIV)
   `LLS_ASSERT_NEXT(a_fill_nonzero, clock, reset, state_ff == S_FIX, fill_ff != '0)

endmodule

// ===== tb/sv/lls_smoother_checker.sv =====
`timescale 1ns / 1ps

module lls_smoother_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // sample[11:0], zero pad
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [15:0]                         rsp_tdata,   // average_mv[11:0], zero pad
   input  logic [2:0]                          rsp_tuser,   // bright, led_on, changed
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [lls_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lls_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                  mismatches,
   output int                                  outstanding
);

   typedef struct packed {
      logic [lls_pkg::AVG_W-1:0] average_mv;
      logic                      bright;
      logic                      led_on;
      logic                      changed;
   } light_reading_type;

   logic                         convert_raw;
   logic [lls_pkg::AVG_W-1:0]    threshold_high;
   logic [lls_pkg::AVG_W-1:0]    threshold_low;
   logic [lls_pkg::SAMPLE_W-1:0] window_mv [lls_pkg::WINDOW];
   int unsigned                  write_slot;
   int unsigned                  fill_count;
   int unsigned                  running_total;
   logic                         light_bright;
   int                           failures = 0;
   light_reading_type            predicted_readings [$];
   light_reading_type            oldest;

   // advances the smoothing window and the light state by one sample
   function automatic light_reading_type smooth_sample(
         input logic [lls_pkg::SAMPLE_W-1:0] sample);
      int unsigned       mv;
      int unsigned       average;
      logic              next_bright;
      light_reading_type reading;
      mv = 32'(sample);
      if (convert_raw)
         mv = (mv * lls_pkg::MV_FULL_SCALE) / lls_pkg::CODE_FULL_SCALE;
      if (fill_count == lls_pkg::WINDOW)
         running_total -= 32'(window_mv[write_slot[lls_pkg::SLOT_W-1:0]]);
      else
         fill_count++;
      window_mv[write_slot[lls_pkg::SLOT_W-1:0]] = mv[lls_pkg::SAMPLE_W-1:0];
      running_total += mv;
      write_slot = (write_slot == lls_pkg::WINDOW - 1) ? 0 : write_slot + 1;
      average = running_total / fill_count;
      next_bright = light_bright ? (average > 32'(threshold_low))
                                 : (average >= 32'(threshold_high));
      reading.average_mv = average[lls_pkg::AVG_W-1:0];
      reading.bright     = next_bright;
      reading.led_on     = ~next_bright;
      reading.changed    = (next_bright != light_bright);
      light_bright = next_bright;
      return reading;
   endfunction

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         convert_raw    = lls_pkg::CONVERT_RAW_RESET;
         threshold_high = lls_pkg::THRESHOLD_HIGH_RESET;
         threshold_low  = lls_pkg::THRESHOLD_LOW_RESET;
         foreach (window_mv[i])
            window_mv[i] = '0;
         write_slot     = 0;
         fill_count     = 0;
         running_total  = 0;
         light_bright   = 1'b0;
         predicted_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lls_pkg::CSR_CONVERT_RAW: begin
                  convert_raw = csr_data[0];
               end
               lls_pkg::CSR_THRESHOLD_HIGH: begin
                  threshold_high = csr_data;
               end
               lls_pkg::CSR_THRESHOLD_LOW: begin
                  threshold_low = csr_data;
               end
               default: begin
               end
            endcase
         end
         // compare before taking a new request so a same-edge request cannot match
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_readings.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, actual average %0d flags %b",
                        $time, rsp_tdata[lls_pkg::AVG_W-1:0], rsp_tuser);
            end else begin
               oldest = predicted_readings.pop_front();
               check_field("average_mv", 32'(oldest.average_mv),
                           32'(rsp_tdata[lls_pkg::AVG_W-1:0]));
               check_field("bright", 32'(oldest.bright), 32'(rsp_tuser[0]));
               check_field("led_on", 32'(oldest.led_on), 32'(rsp_tuser[1]));
               check_field("changed", 32'(oldest.changed), 32'(rsp_tuser[2]));
            end
         end
         if (req_tvalid && req_tready)
            predicted_readings.push_back(smooth_sample(req_tdata[lls_pkg::SAMPLE_W-1:0]));
      end
      mismatches  <= failures;
      outstanding <= predicted_readings.size();
   end

endmodule

// ===== tb/sv/tb_light_level_smoother_with_hysteresis.sv =====
`timescale 1ns / 1ps

module tb_light_level_smoother_with_hysteresis;

   localparam logic [lls_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int SAMPLE_MAX = 4095;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [15:0]                     req_tdata;   // sample[11:0], zero pad
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [15:0]                     rsp_tdata;   // average_mv[11:0], zero pad
   logic [2:0]                      rsp_tuser;   // bright, led_on, changed
   logic                            csr_valid;
   logic                            csr_ready;
   logic [lls_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lls_pkg::CSR_DATA_W-1:0]  csr_data;

   int   mismatches;
   int   outstanding;
   int   rsp_hold = 0;
   logic steady;
   logic raw_mode;
   int   thr_high;
   int   thr_low;

   light_level_smoother_with_hysteresis DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lls_smoother_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 16);
      return $urandom_range(30, 120);
   endfunction

   function automatic int clamp_sample(input int value);
      if (value < 0)
         return 0;
      if (value > SAMPLE_MAX)
         return SAMPLE_MAX;
      return value;
   endfunction

   // a level near one of the thresholds most of the time, in the current input units
   function automatic int pick_level();
      int mv;
      case ($urandom_range(0, 9))
         0: begin
            return 0;
         end
         1: begin
            return SAMPLE_MAX;
         end
         2, 3: begin
            return $urandom_range(0, SAMPLE_MAX);
         end
         default: begin
            mv = ($urandom_range(0, 1) != 0) ? thr_high : thr_low;
            mv = mv + int'($urandom_range(0, 80)) - 40;
         end
      endcase
      if (raw_mode)
         mv = mv * lls_pkg::CODE_FULL_SCALE / lls_pkg::MV_FULL_SCALE;
      return clamp_sample(mv);
   endfunction

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_tready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready = 1'b1;
         rsp_hold = pick_gap();
      end
   end

   task automatic send_sample(input int sample);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {4'b0000, sample[lls_pkg::SAMPLE_W-1:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_csr(input logic [lls_pkg::CSR_INDEX_W-1:0] index,
                            input logic [lls_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic reconfigure(input logic raw, input int high, input int low);
      logic [lls_pkg::CSR_DATA_W-1:0] word;
      req_idle();
      while (outstanding != 0) @(posedge clock);
      word = lls_pkg::CSR_DATA_W'($urandom_range(0, SAMPLE_MAX));
      word[0] = raw;
      write_csr(lls_pkg::CSR_CONVERT_RAW, word);
      write_csr(lls_pkg::CSR_THRESHOLD_HIGH, high[lls_pkg::CSR_DATA_W-1:0]);
      write_csr(lls_pkg::CSR_THRESHOLD_LOW, low[lls_pkg::CSR_DATA_W-1:0]);
      raw_mode = raw;
      thr_high = high;
      thr_low  = low;
      steady   = ($urandom_range(0, 3) == 0);
   endtask

   // runs of a noisy level so the average settles and crosses the thresholds
   task automatic send_runs(input int count);
      int sent;
      int run_len;
      int level;
      int spread;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(1, 25);
         level   = pick_level();
         spread  = $urandom_range(0, 30);
         repeat (run_len) begin
            if (sent < count) begin
               if ($urandom_range(0, 9) == 0)
                  send_sample($urandom_range(0, SAMPLE_MAX));
               else
                  send_sample(clamp_sample(level + int'($urandom_range(0, 2 * spread)) - spread));
               sent++;
            end
         end
      end
   endtask

   initial begin
      int high;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      steady     = 1'b0;
      raw_mode   = lls_pkg::CONVERT_RAW_RESET;
      thr_high   = int'(lls_pkg::THRESHOLD_HIGH_RESET);
      thr_low    = int'(lls_pkg::THRESHOLD_LOW_RESET);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // register defaults: raw codes at both ends of the range and one in between
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(727);

      // millivolt mode: average lands exactly on the low, then the high threshold
      reconfigure(1'b0, 600, 400);
      repeat (10) send_sample(400);
      repeat (10) send_sample(600);
      send_sample(SAMPLE_MAX);
      send_sample(0);

      reconfigure(1'b1, 600, 400);
      send_runs(190);
      reconfigure(1'b0, SAMPLE_MAX, SAMPLE_MAX);
      send_runs(190);
      reconfigure(1'b0, 0, 0);
      write_csr(CSR_UNUSED_INDEX, lls_pkg::CSR_DATA_W'($urandom_range(0, SAMPLE_MAX)));
      send_runs(190);
      // low threshold above the high one
      high = $urandom_range(200, 1500);
      reconfigure(1'b1, high, high + int'($urandom_range(1, 800)));
      send_runs(190);
      repeat (6) begin
         high = $urandom_range(100, 3300);
         reconfigure(1'($urandom_range(0, 1)), high, int'($urandom_range(0, high)));
         send_runs(190);
      end

      req_idle();
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
